// ----- rtl/nfcv4_pkg.sv -----
// shared types, codes and encoding functions for the nfc-v 1-of-4 frame encoder
`default_nettype none
package nfcv4_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned IDX_W    = 4;

    localparam logic [BYTE_W-1:0] SOF_BYTE  = 8'h21;
    localparam logic [BYTE_W-1:0] EOF_BYTE  = 8'h04;
    localparam logic [BYTE_W-1:0] PAIR_BASE = 8'h02;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8408;

    localparam logic [IDX_W-1:0] LEN_START  = 4'd1;
    localparam logic [IDX_W-1:0] LEN_DATA   = 4'd4;
    localparam logic [IDX_W-1:0] LEN_FINISH = 4'd9;
    localparam logic [IDX_W-1:0] IDX_EOF    = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_DATA   = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef struct packed {
        logic              init;
        logic              fold;
        logic [BYTE_W-1:0] data;
    } t_crc_ctl;

    function automatic logic [CRC_W-1:0] f_crc_fold(logic [CRC_W-1:0] crc,
                                                   logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [IDX_W-1:0] f_run_len(logic [OP_W-1:0] op);
        logic [IDX_W-1:0] len;
        case (op)
            OP_START:  len = LEN_START;
            OP_DATA:   len = LEN_DATA;
            OP_FINISH: len = LEN_FINISH;
            default:   len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] f_symbol(logic [OP_W-1:0] op,
                                                   logic [CRC_W-1:0] word,
                                                   logic [IDX_W-1:0] idx);
        logic [1:0]        pair;
        logic [BYTE_W-1:0] sym;
        pair = word[{idx[2:0], 1'b0} +: 2];
        sym  = PAIR_BASE << {pair, 1'b0};
        case (op)
            OP_START:  sym = SOF_BYTE;
            OP_FINISH: begin
                if (idx == IDX_EOF) begin
                    sym = EOF_BYTE;
                end
            end
            default:   ;
        endcase
        return sym;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/nfcv_one_of_four_frame_encoder.sv -----
// nfc-v 1-of-4 request frame encoder top level
// the first symbol of an item passes through the input register, then the output register
// throughput: one output symbol per cycle when not stalled; start 1 symbol, data 4, finish 9
// the output channel sets the rate; no new item is taken while a symbol run is active
// reset: synchronous active low, empties input and output registers, crc to 0xffff
`default_nettype none
module nfcv_one_of_four_frame_encoder
    import nfcv4_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,   // data_byte
    input  wire logic [OP_W-1:0]   i_s_tuser,   // op
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,   // symbol_byte
    output logic                   o_m_tlast
);

    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [BYTE_W-1:0] r_in_data;
    logic              take;
    t_crc_ctl          crc_ctl;
    logic [CRC_W-1:0]  crc;

    assign o_s_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
    end

    nfcv4_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    nfcv4_symbol_gen u_symbol_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item_op    (r_in_op),
        .i_item_data  (r_in_data),
        .i_crc        (crc),
        .o_take       (take),
        .o_crc_ctl    (crc_ctl),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

endmodule
`default_nettype wire

// ----- rtl/nfcv4_crc.sv -----
// running iso 15693 crc-16 register
`default_nettype none
module nfcv4_crc
    import nfcv4_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_crc_ctl         i_ctl,
    output logic [CRC_W-1:0]      o_crc
);

    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.fold) begin
            n_crc = f_crc_fold(r_crc, i_ctl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule
`default_nettype wire

// ----- rtl/nfcv4_symbol_gen.sv -----
// symbol run sequencer with output register
`default_nettype none
module nfcv4_symbol_gen
    import nfcv4_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    input  wire logic [OP_W-1:0]   i_item_op,
    input  wire logic [BYTE_W-1:0] i_item_data,
    input  wire logic [CRC_W-1:0]  i_crc,
    output logic                   o_take,
    output t_crc_ctl               o_crc_ctl,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,   // symbol_byte
    output logic                   o_m_tlast
);

    logic              r_act;
    logic [OP_W-1:0]   r_kind;
    logic [CRC_W-1:0]  r_word;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    logic              n_act;
    logic [OP_W-1:0]   n_kind;
    logic [CRC_W-1:0]  n_word;
    logic [IDX_W-1:0]  n_idx;
    logic              n_out_valid;
    logic [BYTE_W-1:0] n_out_data;
    logic              n_out_last;

    logic              slot_free;
    logic              is_none;
    logic [IDX_W-1:0]  act_len;
    logic [IDX_W-1:0]  new_len;
    logic [CRC_W-1:0]  new_word;

    assign slot_free = !r_out_valid || i_m_tready;
    assign is_none   = (i_item_op != OP_START) && (i_item_op != OP_DATA)
                       && (i_item_op != OP_FINISH);
    assign act_len   = f_run_len(r_kind);
    assign new_len   = f_run_len(i_item_op);
    assign new_word  = (i_item_op == OP_FINISH) ? ~i_crc
                                                : {{(CRC_W-BYTE_W){1'b0}}, i_item_data};
    assign o_take    = i_item_valid && !r_act && (slot_free || is_none);

    always_comb begin
        o_crc_ctl.init = o_take && (i_item_op == OP_START);
        o_crc_ctl.fold = o_take && (i_item_op == OP_DATA);
        o_crc_ctl.data = i_item_data;
    end

    always_comb begin
        n_act       = r_act;
        n_kind      = r_kind;
        n_word      = r_word;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (slot_free) begin
            n_out_valid = 1'b0;
            if (r_act) begin
                n_out_valid = 1'b1;
                n_out_data  = f_symbol(r_kind, r_word, r_idx);
                n_out_last  = (r_idx == act_len - 1'b1);
                n_idx       = r_idx + 1'b1;
                if (r_idx == act_len - 1'b1) begin
                    n_act = 1'b0;
                end
            end else if (o_take && !is_none) begin
                n_out_valid = 1'b1;
                n_out_data  = f_symbol(i_item_op, new_word, '0);
                n_out_last  = (new_len == LEN_START);
                n_kind      = i_item_op;
                n_word      = new_word;
                n_idx       = {{(IDX_W-1){1'b0}}, 1'b1};
                n_act       = (new_len != LEN_START);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_act       <= n_act;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_word     <= n_word;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_act_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> r_out_valid)
        else $error("run active without a pending symbol");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_idx < act_len) && (r_idx != '0))
        else $error("symbol index outside run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_act)
        else $error("last symbol while run still active");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> !o_crc_ctl.init && !o_crc_ctl.fold)
        else $error("crc updated during a run");
`endif

endmodule
`default_nettype wire
